FILE: hdl/pst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the polygon scanline span table.
// Used by the controller, the datapath and the top level; depends on nothing.
package pst_pkg;

   localparam int COORD_W   = 10;
   localparam int LEFT_W    = 11;
   localparam int DIV_CNT_W = 4;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(COORD_W);

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_WALK,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic walk_step;
      logic clr_step;
      logic rd_issue;
   } cmd_type;

   typedef struct packed {
      logic horiz;
      logic div_last;
      logic walk_last;
      logic clr_last;
   } sts_type;

endpackage

FILE: hdl/pst_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package needed.
module pst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/pst_ctrl.sv
`timescale 1ns / 1ps
// Controller for the span table: sequences clear, divide, row walk and read.
// Depends on pst_pkg for the state, operation, command and status types.
module pst_ctrl import pst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_operation,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               case (req_operation)
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_ADD:   state_in = ST_DIV;
                  OP_READ:  state_in = ST_READ;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            // a horizontal edge touches no row
            if (sts.horiz) state_in = ST_IDLE;
            else if (sts.div_last) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (sts.walk_last) state_in = ST_IDLE;
         end
         ST_READ: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_DIV:  cmd.div_step = !sts.horiz;
         ST_WALK: cmd.walk_step = 1'b1;
         ST_READ: cmd.rd_issue = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_READ) |-> ##2 rsp_valid)
      else $error("read transfer did not produce a result two cycles later");

endmodule

FILE: hdl/pst_dp.sv
`timescale 1ns / 1ps
// Datapath for the span table: request registers, shift-subtract divider,
// incremental row stepper, span RAM and read-modify-write stage.
// Depends on pst_pkg and pst_ram.
module pst_dp import pst_pkg::*; #(
   parameter int ROWS = 1024,
   parameter int COLS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [COORD_W-1:0] req_start_x,
   input  logic [COORD_W-1:0] req_start_y,
   input  logic [COORD_W-1:0] req_end_x,
   input  logic [COORD_W-1:0] req_end_y,
   input  logic [COORD_W-1:0] req_query_row,
   output logic [LEFT_W-1:0]  rsp_span_left,
   output logic [COORD_W-1:0] rsp_span_right,
   output logic               rsp_span_empty
);

   // rows past the coordinate range can never be addressed
   localparam int DEPTH = (ROWS < (1 << COORD_W)) ? ROWS : (1 << COORD_W);
   localparam int AW    = $clog2(DEPTH);
   localparam bit FULL  = (DEPTH == (1 << COORD_W));
   localparam int LW    = ($clog2(COLS + 1) > LEFT_W) ? $clog2(COLS + 1) : LEFT_W;
   localparam int DW    = LW + COORD_W;
   localparam logic [LW-1:0] LEFT_RST = LW'(COLS);

   // request and edge setup
   logic [COORD_W-1:0] xl_ff, yu_ff, dy_ff, qrow_ff;
   logic               neg_ff, horiz_ff;
   // divider
   logic [COORD_W-1:0] dvd_ff;
   logic [COORD_W-1:0] rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   // row stepper
   logic [COORD_W-1:0] row_ff, acc_q_ff, acc_r_ff;
   // write stage
   logic [COORD_W-1:0] x_p_ff;
   logic [AW-1:0]      addr_p_ff;
   logic               wen_p_ff;
   // clearing pass
   logic [AW-1:0]      clr_ff;

   logic               swap;
   logic [COORD_W-1:0] xl, yl, xu, yu;
   logic [COORD_W:0]   rem_sh, r_sum;
   logic               rem_ge, r_wrap, row_ok, qrow_ok;
   logic [COORD_W-1:0] x_cur;
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [DW-1:0]      wr_data, rd_data;
   logic [LW-1:0]      old_left, new_left, left_v;
   logic [COORD_W-1:0] old_right, new_right, right_v;

   assign swap = req_start_y > req_end_y;
   assign xl   = swap ? req_end_x   : req_start_x;
   assign yl   = swap ? req_end_y   : req_start_y;
   assign xu   = swap ? req_start_x : req_end_x;
   assign yu   = swap ? req_start_y : req_end_y;

   assign rem_sh = {rem_ff, dvd_ff[COORD_W-1]};
   assign rem_ge = rem_sh >= {1'b0, dy_ff};

   // quotient and remainder of |dx|/dy sit in dvd_ff and rem_ff after the divide
   assign r_sum  = {1'b0, acc_r_ff} + {1'b0, rem_ff};
   assign r_wrap = r_sum >= {1'b0, dy_ff};
   assign x_cur  = neg_ff ? (xl_ff - acc_q_ff) : (xl_ff + acc_q_ff);
   assign row_ok = FULL || (row_ff < COORD_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
         wen_p_ff   <= 1'b0;
         clr_ff     <= '0;
      end else begin
         wen_p_ff <= cmd.walk_step && row_ok;
         if (cmd.load) begin
            div_cnt_ff <= DIV_STEPS;
            clr_ff     <= '0;
         end else begin
            if (cmd.div_step) div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
            if (cmd.clr_step) clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xl_ff    <= xl;
         yu_ff    <= yu;
         dy_ff    <= yu - yl;
         neg_ff   <= xu < xl;
         horiz_ff <= req_start_y == req_end_y;
         qrow_ff  <= req_query_row;
         dvd_ff   <= (xu < xl) ? (xl - xu) : (xu - xl);
         rem_ff   <= '0;
         row_ff   <= yl;
         acc_q_ff <= '0;
         acc_r_ff <= '0;
      end else if (cmd.div_step) begin
         // partial remainder stays below the divisor, so it fits the coordinate width
         rem_ff <= rem_ge ? COORD_W'(rem_sh - {1'b0, dy_ff}) : rem_sh[COORD_W-1:0];
         dvd_ff <= {dvd_ff[COORD_W-2:0], rem_ge};
      end else if (cmd.walk_step) begin
         row_ff   <= row_ff + COORD_W'(1);
         acc_r_ff <= r_wrap ? COORD_W'(r_sum - {1'b0, dy_ff}) : r_sum[COORD_W-1:0];
         acc_q_ff <= acc_q_ff + dvd_ff + COORD_W'(r_wrap);
      end
      if (cmd.walk_step) begin
         x_p_ff    <= x_cur;
         addr_p_ff <= row_ff[AW-1:0];
      end
   end

   // read-modify-write: the row read during a walk cycle is widened and written back in the next cycle
   assign old_left  = rd_data[DW-1:COORD_W];
   assign old_right = rd_data[COORD_W-1:0];
   assign new_left  = (LW'(x_p_ff) < old_left) ? LW'(x_p_ff) : old_left;
   assign new_right = (x_p_ff > old_right) ? x_p_ff : old_right;

   assign wr_en   = wen_p_ff || cmd.clr_step;
   assign wr_addr = cmd.clr_step ? clr_ff : addr_p_ff;
   assign wr_data = cmd.clr_step ? {LEFT_RST, {COORD_W{1'b0}}} : {new_left, new_right};
   assign rd_addr = cmd.rd_issue ? qrow_ff[AW-1:0] : row_ff[AW-1:0];

   pst_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_span_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign qrow_ok = FULL || (qrow_ff < COORD_W'(DEPTH));
   assign left_v  = qrow_ok ? old_left  : LEFT_RST;
   assign right_v = qrow_ok ? old_right : '0;

   assign rsp_span_left  = left_v[LEFT_W-1:0];
   assign rsp_span_right = right_v;
   assign rsp_span_empty = left_v > LW'(right_v);

   assign sts.horiz     = horiz_ff;
   assign sts.div_last  = div_cnt_ff == DIV_CNT_W'(1);
   assign sts.walk_last = row_ff == yu_ff;
   assign sts.clr_last  = clr_ff == AW'(DEPTH - 1);

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (acc_r_ff < dy_ff))
      else $error("row stepper remainder reached the divisor");

   a_no_wr_clash: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !wen_p_ff)
      else $error("clearing write collided with a row update");

endmodule

FILE: hdl/polygon_scanline_span_table.sv
`timescale 1ns / 1ps
// Polygon scanline span table: per-row leftmost/rightmost x for polygon fill.
// Request channel: drive req_* and raise start; the transfer happens at a rising
// edge with start high and busy low. req_operation selects clear (0), add edge (1)
// or read one row (2); code 3 is taken and ignored.
// Result channel: only a read answers. rsp_valid is high for exactly one cycle with
// rsp_span_left/right/empty; the receiver cannot stall it and must take it then.
// Sequence after the transfer, until busy falls:
//   read     the row is read from the span RAM, then the result is shown
//   add edge busy falls with no RAM access for a horizontal edge, else there is
//            a 10-step shift-subtract divide, then one row per cycle through the
//            span RAM (read, then write-back of the widened span in the next cycle)
//   clear    min(ROWS, 1024) RAM rows are cleared, one RAM row per cycle
// Reset runs the same clearing pass with busy high.
// Depends on pst_pkg, pst_ctrl, pst_dp and pst_ram.
module polygon_scanline_span_table import pst_pkg::*; #(
   parameter int ROWS = 1024,
   parameter int COLS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [COORD_W-1:0] req_start_x,
   input  logic [COORD_W-1:0] req_start_y,
   input  logic [COORD_W-1:0] req_end_x,
   input  logic [COORD_W-1:0] req_end_y,
   input  logic [COORD_W-1:0] req_query_row,
   output logic               rsp_valid,
   output logic [LEFT_W-1:0]  rsp_span_left,
   output logic [COORD_W-1:0] rsp_span_right,
   output logic               rsp_span_empty
);

   cmd_type cmd;
   sts_type sts;

   pst_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   pst_dp #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_query_row  (req_query_row),
      .rsp_span_left  (rsp_span_left),
      .rsp_span_right (rsp_span_right),
      .rsp_span_empty (rsp_span_empty)
   );

endmodule
